### sv/acpd_pkg.sv
// Shared widths, field positions and item codes for the autocorrelation peak detector.
package acpd_pkg;

    localparam int THRESH_W    = 36;
    localparam int MAG_OUT_W   = 36;
    localparam int DIST_OUT_W  = 6;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_USER_W  = 2;

    localparam int MAG_LSB     = 0;
    localparam int DIST_LSB    = MAG_LSB + MAG_OUT_W;
    localparam int PAD_W       = OUT_DATA_W - DIST_LSB - DIST_OUT_W;

    localparam int USER_TRACKING = 0;
    localparam int USER_FOUND    = 1;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

endpackage

### sv/autocorrelation_peak_detector.sv
// Delayed-autocorrelation sync detector: running lagged correlation and peak search.
// An accepted item is held in the input register, processed from there into the output registers,
// and its result is offered on the master side from then on. Throughput: one item per cycle
// unless m_tready stalls the output; the running-sum update (one multiply and one add into the
// sum register) and the threshold and peak compares all close between the two registers.
// Reset: rst_n is asynchronous and active low; it empties both registers, zeroes the delay
// line, the running sum and the detection state, and sets the threshold to zero.
module autocorrelation_peak_detector #(
    parameter int LAG         = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [acpd_pkg::THRESH_W-1:0]         cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample, zero padding
    input  logic                                  s_tuser,  // kind
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [acpd_pkg::OUT_DATA_W-1:0]       m_tdata,  // corr_magnitude, peak_distance, pad
    output logic [acpd_pkg::OUT_USER_W-1:0]       m_tuser   // tracking, found
);

    localparam int LINE_LEN = 2 * LAG;
    localparam int SUM_W    = 2 * SAMPLE_BITS + 1 + $clog2(LAG);
    localparam int MAG_W    = SUM_W - 1;
    localparam int PROD_W   = 2 * SAMPLE_BITS + 1;
    localparam int CMP_W    = (MAG_W > acpd_pkg::THRESH_W) ? MAG_W : acpd_pkg::THRESH_W;
    localparam int CNT_W    = $clog2(LAG + 1);
    localparam int BI_W     = (LAG > 1) ? $clog2(LAG) : 1;
    localparam int DIST_W   = $clog2(LAG + 2);

    logic [acpd_pkg::THRESH_W-1:0]     threshold_reg;

    logic                              in_valid_reg;
    logic                              in_kind_reg;
    logic signed [SAMPLE_BITS-1:0]     in_sample_reg;

    logic signed [SAMPLE_BITS-1:0]     taps_reg [LINE_LEN];
    logic signed [SUM_W-1:0]           sum_reg;
    logic                              tracking_reg;
    logic                              done_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [MAG_W-1:0]                  best_value_reg;
    logic [BI_W-1:0]                   best_index_reg;

    logic                              out_valid_reg;
    logic [acpd_pkg::MAG_OUT_W-1:0]    out_mag_reg;
    logic                              out_tracking_reg;
    logic                              out_found_reg;
    logic [acpd_pkg::DIST_OUT_W-1:0]   out_dist_reg;

    logic                              proc_fire;
    logic                              in_fire;
    logic                              do_sample;
    logic                              do_restart;

    logic signed [SAMPLE_BITS-1:0]     x_lag;
    logic signed [SAMPLE_BITS-1:0]     x_old;
    logic signed [SAMPLE_BITS:0]       x_diff;
    logic signed [PROD_W-1:0]          delta;
    logic signed [SUM_W-1:0]           sum_next;
    logic [SUM_W-1:0]                  sum_abs;
    logic [MAG_W-1:0]                  mag;
    logic [CNT_W-1:0]                  count_inc;
    logic [DIST_W-1:0]                 dist_full;

    logic                              tracking_next;
    logic                              done_next;
    logic [CNT_W-1:0]                  count_next;
    logic [MAG_W-1:0]                  best_value_next;
    logic [BI_W-1:0]                   best_index_next;
    logic                              res_tracking;
    logic                              res_found;
    logic [acpd_pkg::DIST_OUT_W-1:0]   res_dist;

    assign proc_fire  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || proc_fire;
    assign in_fire    = s_tvalid && s_tready;
    assign do_restart = proc_fire && (in_kind_reg == acpd_pkg::KIND_RESTART);
    assign do_sample  = proc_fire && (in_kind_reg == acpd_pkg::KIND_SAMPLE) && !done_reg;

    assign x_lag     = taps_reg[LAG-1];
    assign x_old     = taps_reg[LINE_LEN-1];
    assign x_diff    = (SAMPLE_BITS + 1)'(in_sample_reg) - (SAMPLE_BITS + 1)'(x_old);
    assign delta     = PROD_W'(x_lag) * PROD_W'(x_diff);
    assign sum_next  = sum_reg + SUM_W'(delta);
    assign sum_abs   = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    assign mag       = sum_abs[MAG_W-1:0];
    assign count_inc = CNT_W'(count_reg + 1'b1);
    assign dist_full = DIST_W'(LAG + 1) - DIST_W'(best_index_reg);

    always_comb
    begin
        tracking_next   = tracking_reg;
        done_next       = done_reg;
        count_next      = count_reg;
        best_value_next = best_value_reg;
        best_index_next = best_index_reg;
        res_tracking    = 1'b0;
        res_found       = 1'b0;
        res_dist        = '0;
        if (!tracking_reg)
        begin
            if (CMP_W'(mag) > CMP_W'(threshold_reg))
            begin
                tracking_next   = 1'b1;
                count_next      = '0;
                best_value_next = mag;
                best_index_next = '0;
                res_tracking    = 1'b1;
            end
        end
        else
        begin
            count_next = count_inc;
            if (count_inc < CNT_W'(LAG))
            begin
                if (mag > best_value_reg)
                begin
                    best_value_next = mag;
                    best_index_next = BI_W'(count_inc);
                end
                res_tracking = 1'b1;
            end
            else
            begin
                tracking_next = 1'b0;
                done_next     = 1'b1;
                res_found     = 1'b1;
                res_dist      = acpd_pkg::DIST_OUT_W'(dist_full);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_kind_reg   <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_LEN; i++)
            begin
                taps_reg[i] <= '0;
            end
            sum_reg        <= '0;
            tracking_reg   <= 1'b0;
            done_reg       <= 1'b0;
            count_reg      <= '0;
            best_value_reg <= '0;
            best_index_reg <= '0;
        end
        else if (do_restart)
        begin
            for (int i = 0; i < LINE_LEN; i++)
            begin
                taps_reg[i] <= '0;
            end
            sum_reg        <= '0;
            tracking_reg   <= 1'b0;
            done_reg       <= 1'b0;
            count_reg      <= '0;
            best_value_reg <= '0;
            best_index_reg <= '0;
        end
        else if (do_sample)
        begin
            taps_reg[0] <= in_sample_reg;
            for (int i = 1; i < LINE_LEN; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
            sum_reg        <= sum_next;
            tracking_reg   <= tracking_next;
            done_reg       <= done_next;
            count_reg      <= count_next;
            best_value_reg <= best_value_next;
            best_index_reg <= best_index_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            if (do_sample)
            begin
                out_mag_reg      <= acpd_pkg::MAG_OUT_W'(mag);
                out_tracking_reg <= res_tracking;
                out_found_reg    <= res_found;
                out_dist_reg     <= res_dist;
            end
            else
            begin
                out_mag_reg      <= '0;
                out_tracking_reg <= 1'b0;
                out_found_reg    <= 1'b0;
                out_dist_reg     <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{acpd_pkg::PAD_W{1'b0}}, out_dist_reg, out_mag_reg};

    always_comb
    begin
        m_tuser                          = '0;
        m_tuser[acpd_pkg::USER_TRACKING] = out_tracking_reg;
        m_tuser[acpd_pkg::USER_FOUND]    = out_found_reg;
    end

endmodule

### sv/acpd_checker.sv
// Port-level assertion checker for the autocorrelation peak detector, with its bind.
module acpd_checker #(
    parameter int LAG = 32
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [acpd_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [acpd_pkg::OUT_USER_W-1:0]   m_tuser
);

    logic                              out_tracking;
    logic                              out_found;
    logic [acpd_pkg::DIST_OUT_W-1:0]   out_dist;

    assign out_tracking = m_tuser[acpd_pkg::USER_TRACKING];
    assign out_found    = m_tuser[acpd_pkg::USER_FOUND];
    assign out_dist     = m_tdata[acpd_pkg::DIST_LSB +: acpd_pkg::DIST_OUT_W];

    // A completed detection closes the tracking window on the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_tracking && out_found))
    else $error("found and tracking both set on one item");

    // The peak distance is reported only together with found.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_found) |-> (out_dist == '0))
    else $error("peak distance nonzero without found");

    // A found item points back at least two samples and at most one window plus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_found) |->
            (out_dist >= acpd_pkg::DIST_OUT_W'(2) &&
             out_dist <= acpd_pkg::DIST_OUT_W'(LAG + 1)))
    else $error("peak distance out of range on found");

    // A stalled item stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output item changed");

endmodule

bind autocorrelation_peak_detector acpd_checker #(
    .LAG (LAG)
) u_acpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/tb_autocorrelation_peak_detector.sv
// Self-checking testbench for the autocorrelation peak detector with directed and random stimulus.
`timescale 1ns / 1ps

module tb_autocorrelation_peak_detector;

    localparam int  LAG           = 32;
    localparam int  LINE_LEN      = 2 * LAG;
    localparam int  PHASE_ITEMS   = 60;
    localparam int  RANDOM_PHASES = 6;
    localparam int  DRAIN_CYCLES  = 6;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  DIR_ROWS      = 20;

    typedef struct packed {
        logic [acpd_pkg::MAG_OUT_W-1:0]  mag;
        logic                            trk;
        logic                            fnd;
        logic [acpd_pkg::DIST_OUT_W-1:0] peak_dist;
    } corr_result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_THRESH
    } row_op_t;

    typedef struct packed {
        row_op_t                       op;
        logic                          kind;
        logic [15:0]                   smp;
        logic [15:0]                   reps;
        logic                          chk;
        corr_result_t                  want;
        logic [acpd_pkg::THRESH_W-1:0] thr;
    } dir_row_t;

    localparam corr_result_t ZERO_RES = '0;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [acpd_pkg::THRESH_W-1:0]     cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [15:0]                       s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [acpd_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [acpd_pkg::OUT_USER_W-1:0]   m_tuser;

    logic signed [15:0]                corr_line [LINE_LEN];
    int                                line_ptr;
    longint                            corr_sum;
    logic                              trk_on;
    logic                              det_done;
    int                                trk_count;
    longint                            peak_mag;
    int                                peak_pos;
    logic [acpd_pkg::THRESH_W-1:0]     thresh_shadow;

    corr_result_t            expected_corr [$];
    int                      mismatch_count;
    int                      cycle_count;
    int                      tx_idle_pct;
    int                      rx_stall_pct;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM,   acpd_pkg::KIND_RESTART, 16'h0000, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h7FFF, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h0000, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'hFFFF, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h5555, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'hAAAA, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_RESTART, 16'hFFFF, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd32, 1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd1,  1'b1,
          '{36'd1073741824, 1'b1, 1'b0, 6'd0}, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd31, 1'b0, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd1,  1'b1,
          '{36'd34359738368, 1'b0, 1'b1, 6'd2}, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'd1234, 16'd2,  1'b1, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_RESTART, 16'h0000, 16'd1,  1'b1, ZERO_RES, 36'd0},
        '{ROW_THRESH, acpd_pkg::KIND_SAMPLE,  16'h0000, 16'd0,  1'b0, ZERO_RES,
          36'd34359738367},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd63, 1'b0, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd1,  1'b1,
          '{36'd34359738368, 1'b1, 1'b0, 6'd0}, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd31, 1'b0, ZERO_RES, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_SAMPLE,  16'h8000, 16'd1,  1'b1,
          '{36'd34359738368, 1'b0, 1'b1, 6'd33}, 36'd0},
        '{ROW_ITEM,   acpd_pkg::KIND_RESTART, 16'h0000, 16'd1,  1'b1, ZERO_RES, 36'd0}
    };

    autocorrelation_peak_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_detector();
        for (int k = 0; k < LINE_LEN; k++)
        begin
            corr_line[k] = '0;
        end
        line_ptr  = 0;
        corr_sum  = 0;
        trk_on    = 1'b0;
        det_done  = 1'b0;
        trk_count = 0;
        peak_mag  = 0;
        peak_pos  = 0;
    endtask

    task automatic predict_correlation(input logic kind, input logic [15:0] smp,
                                       output corr_result_t res);
        longint x;
        longint x_lag;
        longint x_old;
        longint mag;
        res = ZERO_RES;
        if (kind == acpd_pkg::KIND_RESTART)
        begin
            clear_detector();
            return;
        end
        if (det_done)
        begin
            return;
        end
        x     = longint'($signed(smp));
        x_old = longint'(corr_line[line_ptr]);
        x_lag = longint'(corr_line[(line_ptr + LAG) % LINE_LEN]);
        corr_sum = corr_sum + x * x_lag - x_lag * x_old;
        corr_line[line_ptr] = smp;
        line_ptr = (line_ptr + 1) % LINE_LEN;
        mag = (corr_sum < 0) ? -corr_sum : corr_sum;

        if (!trk_on)
        begin
            if (mag > longint'(thresh_shadow))
            begin
                trk_on    = 1'b1;
                trk_count = 0;
                peak_mag  = mag;
                peak_pos  = 0;
                res.trk   = 1'b1;
            end
        end
        else
        begin
            trk_count++;
            if (trk_count < LAG)
            begin
                if (mag > peak_mag)
                begin
                    peak_mag = mag;
                    peak_pos = trk_count;
                end
                res.trk = 1'b1;
            end
            else
            begin
                trk_on        = 1'b0;
                det_done      = 1'b1;
                res.fnd       = 1'b1;
                res.peak_dist = acpd_pkg::DIST_OUT_W'(LAG - peak_pos + 1);
            end
        end
        res.mag = mag[acpd_pkg::MAG_OUT_W-1:0];
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic drive_item(input logic kind, input logic [15:0] smp,
                              input logic use_given, input corr_result_t given);
        corr_result_t res;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_tready);
        predict_correlation(kind, smp, res);
        expected_corr.push_back(use_given ? given : res);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_corr.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [acpd_pkg::THRESH_W-1:0] value);
        wait_drained();
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        thresh_shadow  = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        corr_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** autocorrelation_peak_detector: FAILED **");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_corr.size() == 0)
            begin
                report_mismatch("item with nothing pending, tdata", m_tdata, 0);
            end
            else
            begin
                want = expected_corr.pop_front();
                if (m_tdata[acpd_pkg::MAG_LSB +: acpd_pkg::MAG_OUT_W] !== want.mag)
                    report_mismatch("corr_magnitude",
                                    m_tdata[acpd_pkg::MAG_LSB +: acpd_pkg::MAG_OUT_W],
                                    want.mag);
                if (m_tuser[acpd_pkg::USER_TRACKING] !== want.trk)
                    report_mismatch("tracking", m_tuser[acpd_pkg::USER_TRACKING], want.trk);
                if (m_tuser[acpd_pkg::USER_FOUND] !== want.fnd)
                    report_mismatch("found", m_tuser[acpd_pkg::USER_FOUND], want.fnd);
                if (m_tdata[acpd_pkg::DIST_LSB +: acpd_pkg::DIST_OUT_W] !== want.peak_dist)
                    report_mismatch("peak_distance",
                                    m_tdata[acpd_pkg::DIST_LSB +: acpd_pkg::DIST_OUT_W],
                                    want.peak_dist);
            end
        end
    end

    initial
    begin : stimulus
        logic signed [15:0]            pat [LAG];
        logic signed [15:0]            raw;
        logic signed [15:0]            cval;
        logic [15:0]                   smp;
        logic [acpd_pkg::THRESH_W-1:0] thr;
        logic                          kind;
        logic                          paused;
        int                            n;
        int                            mode;
        int                            len;
        int                            shift;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = acpd_pkg::KIND_SAMPLE;
        m_tready       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        thresh_shadow  = '0;
        clear_detector();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].op == ROW_THRESH)
            begin
                write_threshold(dir_rows[r].thr);
            end
            else
            begin
                for (int k = 0; k < dir_rows[r].reps; k++)
                begin
                    drive_item(dir_rows[r].kind, dir_rows[r].smp, dir_rows[r].chk,
                               dir_rows[r].want);
                end
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: thr = '0;
                2: thr = '1;
                4: thr = 36'd34359738367;
                5: thr = acpd_pkg::THRESH_W'($urandom_range(0, 1 << 20));
                default: thr = acpd_pkg::THRESH_W'($urandom) << $urandom_range(0, 3);
            endcase
            write_threshold(thr);
            case (ph)
                1:
                begin
                    tx_idle_pct  = 79;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 79;
                end
                3, 5:
                begin
                    tx_idle_pct  = 24;
                    rx_stall_pct = 24;
                end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase

            n      = 0;
            paused = 1'b0;
            while (n < PHASE_ITEMS)
            begin
                if (det_done)
                begin
                    repeat ($urandom_range(0, 3))
                        drive_item(acpd_pkg::KIND_SAMPLE, 16'($urandom), 1'b0, ZERO_RES);
                    drive_item(acpd_pkg::KIND_RESTART, 16'($urandom), 1'b0, ZERO_RES);
                    n++;
                end
                else
                begin
                    if ($urandom_range(0, 9) < 3)
                    begin
                        drive_item(acpd_pkg::KIND_RESTART, 16'($urandom), 1'b0, ZERO_RES);
                        n++;
                    end
                    mode  = $urandom_range(0, 4);
                    len   = $urandom_range(20, 100);
                    shift = $urandom_range(0, 8);
                    case ($urandom_range(0, 2))
                        0: cval = 16'sh8000;
                        1: cval = 16'sh7FFF;
                        default: cval = 16'($urandom);
                    endcase
                    for (int k = 0; k < LAG; k++)
                    begin
                        raw    = 16'($urandom);
                        pat[k] = raw >>> shift;
                    end
                    for (int i = 0; i < len && n < PHASE_ITEMS && !det_done; i++)
                    begin
                        case (mode)
                            0: smp = 16'($urandom);
                            1: smp = pat[i % LAG];
                            2: smp = cval;
                            3: smp = ((i / LAG) % 2) ? -pat[i % LAG] : pat[i % LAG];
                            default: smp = pat[i % LAG] + 16'($urandom_range(0, 255)) - 16'd128;
                        endcase
                        kind = ($urandom_range(0, 99) == 0) ? acpd_pkg::KIND_RESTART
                                                            : acpd_pkg::KIND_SAMPLE;
                        drive_item(kind, smp, 1'b0, ZERO_RES);
                        n++;
                        if (ph == 1 && !paused && n >= PHASE_ITEMS / 2)
                        begin
                            wait_drained();
                            paused = 1'b1;
                        end
                    end
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("** autocorrelation_peak_detector: PASSED **");
        else
            $display("** autocorrelation_peak_detector: FAILED **");
        $finish;
    end

endmodule

### autocorrelation_peak_detector.f
sv/acpd_pkg.sv
sv/autocorrelation_peak_detector.sv
sv/acpd_checker.sv
verif/tb_autocorrelation_peak_detector.sv
